### hdl/cursor_list_append_from_free_slot_assert.svh
// Assertion macros for the checker of the cursor list block.
// Self-contained; expects clk and rst_n in scope where a macro is used.
`ifndef CURSOR_LIST_APPEND_FROM_FREE_SLOT_ASSERT_SVH
`define CURSOR_LIST_APPEND_FROM_FREE_SLOT_ASSERT_SVH

// Same-cycle implication, off during reset.
`define CLAFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define CLAFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/clafs_pkg.sv
// Shared constants and types for the cursor list block.
// No dependencies.
package clafs_pkg;

    localparam int NODES   = 16;
    localparam int IDX_W   = $clog2(NODES);
    localparam int LINK_W  = $clog2(NODES + 1);
    localparam int CNT_W   = LINK_W;
    localparam int VALUE_W = 32;
    localparam int SLOT_W  = 4;

    typedef logic [LINK_W-1:0] link_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [1:0]        op_t;
    typedef logic [1:0]        status_t;

    // null link
    localparam link_t NIL = link_t'(NODES);

    localparam op_t OP_APPEND = 2'd0;
    localparam op_t OP_PRINT  = 2'd1;
    localparam op_t OP_CLEAR  = 2'd2;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_FULL     = 2'd1;
    localparam status_t ST_NOT_FREE = 2'd2;
    localparam status_t ST_EMPTY    = 2'd3;

endpackage

### hdl/clafs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module clafs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/cursor_list_append_from_free_slot.sv
// Cursor (array-backed) linked list with a free chain, NODES = 16 entries.
// Links and data words sit in two RAMs with a registered read; a sequencer walks them.
// Input transfer: tuser = op (0 append, 1 print, 2 clear, 3 ignored);
// tdata = value in [31:0], slot in [35:32]. Output transfer: tuser = status
// (0 ok, 1 full, 2 slot not free, 3 empty), tdata = item (print data, else 0),
// tlast marks the final result of an input. After reset the link RAM is swept
// (entry i -> i+1) and no input is taken meanwhile; clear runs the same sweep.
// An append walks the free chain up to the chosen slot, then matches, unlinks,
// fills, hooks on at the tail and answers (a tail register avoids walking the
// list); a print reads both RAMs once per hop, the read being registered; a
// not-free answer walks the whole free chain. One input is worked at a time;
// the output register lets the next input be taken while the last result is
// still waiting.
// Depends on clafs_pkg and clafs_ram.
module cursor_list_append_from_free_slot (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value[31:0], slot[35:32], zero pad
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // item[31:0]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast    // last
);

    typedef enum logic [10:0] {
        S_SWEEP = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_FCHK  = 11'b000_0000_0100,
        S_FWAIT = 11'b000_0000_1000,
        S_XWAIT = 11'b000_0001_0000,
        S_PLACE = 11'b000_0010_0000,
        S_TAIL  = 11'b000_0100_0000,
        S_RESP  = 11'b000_1000_0000,
        S_PREAD = 11'b001_0000_0000,
        S_PEMIT = 11'b010_0000_0000,
        S_SPARE = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    clafs_pkg::link_t   free_head_reg, free_head_next;
    clafs_pkg::idx_t    list_head_reg, list_head_next;
    clafs_pkg::idx_t    tail_reg, tail_next;
    clafs_pkg::cnt_t    count_reg, count_next;
    clafs_pkg::link_t   p_reg, p_next;       // walk cursor
    clafs_pkg::link_t   prev_reg, prev_next; // free-chain predecessor
    clafs_pkg::cnt_t    idx_reg, idx_next;   // sweep / print index
    clafs_pkg::status_t resp_reg, resp_next;
    logic               clr_reg, clr_next;   // sweep came from clear
    logic [clafs_pkg::VALUE_W-1:0] value_reg, value_next;
    clafs_pkg::idx_t    slot_reg, slot_next;

    logic                          out_valid_reg, out_valid_next;
    clafs_pkg::status_t            out_status_reg, out_status_next;
    logic [clafs_pkg::VALUE_W-1:0] out_item_reg, out_item_next;
    logic                          out_last_reg, out_last_next;

    // RAM ports
    logic                          link_we, link_re;
    clafs_pkg::idx_t               link_waddr, link_raddr;
    clafs_pkg::link_t              link_wdata, link_rdata;
    logic                          data_we, data_re;
    clafs_pkg::idx_t               data_raddr;
    logic [clafs_pkg::VALUE_W-1:0] data_rdata;

    logic                          in_xfer;
    logic                          out_free;
    clafs_pkg::op_t                in_op;
    logic [clafs_pkg::VALUE_W-1:0] in_value;
    logic [clafs_pkg::SLOT_W-1:0]  in_slot;
    logic                          print_last;

    clafs_ram #(
        .WIDTH (clafs_pkg::LINK_W),
        .DEPTH (clafs_pkg::NODES)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    clafs_ram #(
        .WIDTH (clafs_pkg::VALUE_W),
        .DEPTH (clafs_pkg::NODES)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (slot_reg),
        .wdata (value_reg),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_op         = s_axis_tuser;
    assign in_value      = s_axis_tdata[31:0];
    assign in_slot       = s_axis_tdata[35:32];

    // output register free this cycle (empty, or being taken)
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign print_last    = (clafs_pkg::cnt_t'(idx_reg + 1'b1) == count_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_item_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        list_head_next  = list_head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        p_next          = p_reg;
        prev_next       = prev_reg;
        idx_next        = idx_reg;
        resp_next       = resp_reg;
        clr_next        = clr_reg;
        value_next      = value_reg;
        slot_next       = slot_reg;

        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_item_next   = out_item_reg;
        out_last_next   = out_last_reg;

        link_we    = 1'b0;
        link_waddr = p_reg[clafs_pkg::IDX_W-1:0];
        link_wdata = clafs_pkg::NIL;
        link_re    = 1'b0;
        link_raddr = p_reg[clafs_pkg::IDX_W-1:0];
        data_we    = 1'b0;
        data_re    = 1'b0;
        data_raddr = p_reg[clafs_pkg::IDX_W-1:0];

        case (state_reg)
            S_SWEEP:
            begin
                // rebuild free chain in index order; last entry gets null
                link_we    = 1'b1;
                link_waddr = idx_reg[clafs_pkg::IDX_W-1:0];
                link_wdata = clafs_pkg::link_t'(idx_reg + 1'b1);
                idx_next   = clafs_pkg::cnt_t'(idx_reg + 1'b1);
                if (idx_reg == clafs_pkg::cnt_t'(clafs_pkg::NODES - 1))
                begin
                    clr_next   = 1'b0;
                    resp_next  = clafs_pkg::ST_OK;
                    state_next = clr_reg ? S_RESP : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_xfer)
                begin
                    value_next = in_value;
                    slot_next  = clafs_pkg::idx_t'(in_slot);
                    case (in_op)
                        clafs_pkg::OP_APPEND:
                        begin
                            if (free_head_reg == clafs_pkg::NIL)
                            begin
                                resp_next  = clafs_pkg::ST_FULL;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                p_next     = free_head_reg;
                                prev_next  = clafs_pkg::NIL;
                                state_next = S_FCHK;
                            end
                        end
                        clafs_pkg::OP_PRINT:
                        begin
                            if (count_reg == '0)
                            begin
                                resp_next  = clafs_pkg::ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                p_next     = clafs_pkg::link_t'(list_head_reg);
                                idx_next   = '0;
                                state_next = S_PREAD;
                            end
                        end
                        clafs_pkg::OP_CLEAR:
                        begin
                            free_head_next = '0;
                            list_head_next = '0;
                            count_next     = '0;
                            idx_next       = '0;
                            clr_next       = 1'b1;
                            state_next     = S_SWEEP;
                        end
                        default:
                        begin
                            // unused op: no result, no change
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_FCHK:
            begin
                if (p_reg == clafs_pkg::NIL)
                begin
                    resp_next  = clafs_pkg::ST_NOT_FREE;
                    state_next = S_RESP;
                end
                else if (p_reg == clafs_pkg::link_t'(slot_reg))
                begin
                    // fetch the chosen slot's successor
                    link_re    = 1'b1;
                    link_raddr = slot_reg;
                    state_next = S_XWAIT;
                end
                else
                begin
                    link_re    = 1'b1;
                    prev_next  = p_reg;
                    state_next = S_FWAIT;
                end
            end

            S_FWAIT:
            begin
                p_next     = link_rdata;
                state_next = S_FCHK;
            end

            S_XWAIT:
            begin
                // unlink slot from free chain
                if (prev_reg == clafs_pkg::NIL)
                begin
                    free_head_next = link_rdata;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg[clafs_pkg::IDX_W-1:0];
                    link_wdata = link_rdata;
                end
                state_next = S_PLACE;
            end

            S_PLACE:
            begin
                link_we    = 1'b1;
                link_waddr = slot_reg;
                link_wdata = clafs_pkg::NIL;
                data_we    = 1'b1;
                if (count_reg == '0)
                begin
                    list_head_next = slot_reg;
                    tail_next      = slot_reg;
                    count_next     = clafs_pkg::cnt_t'(count_reg + 1'b1);
                    resp_next      = clafs_pkg::ST_OK;
                    state_next     = S_RESP;
                end
                else
                begin
                    state_next = S_TAIL;
                end
            end

            S_TAIL:
            begin
                link_we    = 1'b1;
                link_waddr = tail_reg;
                link_wdata = clafs_pkg::link_t'(slot_reg);
                tail_next  = slot_reg;
                if (count_reg < clafs_pkg::cnt_t'(clafs_pkg::NODES))
                begin
                    count_next = clafs_pkg::cnt_t'(count_reg + 1'b1);
                end
                resp_next  = clafs_pkg::ST_OK;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = resp_reg;
                    out_item_next   = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_PREAD:
            begin
                link_re    = 1'b1;
                data_re    = 1'b1;
                state_next = S_PEMIT;
            end

            S_PEMIT:
            begin
                // read data holds until the output slot frees up
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = clafs_pkg::ST_OK;
                    out_item_next   = data_rdata;
                    out_last_next   = print_last;
                    p_next          = link_rdata;
                    idx_next        = clafs_pkg::cnt_t'(idx_reg + 1'b1);
                    state_next      = print_last ? S_IDLE : S_PREAD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            free_head_reg <= '0;
            list_head_reg <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            clr_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            list_head_reg <= list_head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        p_reg          <= p_next;
        prev_reg       <= prev_next;
        resp_reg       <= resp_next;
        value_reg      <= value_next;
        slot_reg       <= slot_next;
        out_status_reg <= out_status_next;
        out_item_reg   <= out_item_next;
        out_last_reg   <= out_last_next;
    end

endmodule

### hdl/clafs_checker.sv
// Port-level checker for the cursor list block, bound to the top level.
// Depends on clafs_pkg and cursor_list_append_from_free_slot_assert.svh.
`include "cursor_list_append_from_free_slot_assert.svh"

module clafs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    `CLAFS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

    `CLAFS_ASSERT_IMP(a_err_last, m_axis_tvalid && (m_axis_tuser != clafs_pkg::ST_OK), m_axis_tlast, "error status without tlast")

    `CLAFS_ASSERT_IMP(a_err_zero, m_axis_tvalid && (m_axis_tuser != clafs_pkg::ST_OK), m_axis_tdata == 32'd0, "error status with nonzero item")

    `CLAFS_ASSERT_IMP(a_busy_print, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input taken in the middle of a print")

endmodule

bind cursor_list_append_from_free_slot clafs_checker u_clafs_checker (.*);

### tb/cursor_list_append_from_free_slot_test.sv
// Self-checking bench for the cursor list block: directed script, then random traffic.
// Holds its own copy of the list and free chain to predict every output transfer.
// Depends on clafs_pkg and the cursor_list_append_from_free_slot RTL.
module cursor_list_append_from_free_slot_test;

    import clafs_pkg::*;

    // op code 3 has no name in the package; the block drops it silently
    localparam op_t OP_UNUSED = 2'd3;

    // random items after the directed script; the final stretch runs without idling
    localparam int RANDOM_ITEMS = 234;
    localparam int CALM_ITEMS   = 30;
    // drain after the last expected transfer
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        status_t     status;
        logic [31:0] item;
        logic        last;
    } result_t;

    // one row of the directed script; pinned rows carry a status typed in by hand
    typedef struct {
        op_t         op;
        logic [31:0] value;
        idx_t        slot;
        bit          pinned;
        status_t     status;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // predictor state: links, data words, chain heads and list length
    link_t       link_mem [NODES];
    logic [31:0] word_mem [NODES];
    link_t       free_head;
    idx_t        list_head;
    cnt_t        list_len;

    result_t     pending_results[$];
    script_row_t script[$];
    int unsigned errors = 0;
    bit          calm = 1'b0;

    cursor_list_append_from_free_slot i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Puts every entry back on the free chain in index order and empties the list.
    function automatic void rebuild_chains();
        for (int i = 0; i < NODES; i++)
        begin
            link_mem[i] = (i + 1 < NODES) ? link_t'(i + 1) : NIL;
        end
        free_head = '0;
        list_head = '0;
        list_len  = '0;
    endfunction

    // Applies one command to the predicted list and returns the transfers it causes.
    function automatic void list_step(input op_t op, input logic [31:0] value,
                                      input idx_t slot, output result_t res[$]);
        link_t p;
        link_t prev;
        link_t tail;
        res = {};
        case (op)
            OP_APPEND:
            begin
                if (free_head == NIL)
                begin
                    res.push_back('{ST_FULL, 32'd0, 1'b1});
                end
                else
                begin
                    // look for the slot on the free chain, remembering its predecessor
                    prev = NIL;
                    p    = free_head;
                    while (p != NIL && p != link_t'(slot))
                    begin
                        prev = p;
                        p    = link_mem[p[IDX_W-1:0]];
                    end
                    if (p == NIL)
                    begin
                        res.push_back('{ST_NOT_FREE, 32'd0, 1'b1});
                    end
                    else
                    begin
                        tail = link_t'(list_head);
                        for (int n = 1; n < list_len; n++)
                        begin
                            tail = link_mem[tail[IDX_W-1:0]];
                        end
                        if (prev == NIL)
                            free_head = link_mem[slot];
                        else
                            link_mem[prev[IDX_W-1:0]] = link_mem[slot];
                        word_mem[slot] = value;
                        link_mem[slot] = NIL;
                        if (list_len == 0)
                            list_head = slot;
                        else if (tail != NIL)
                            link_mem[tail[IDX_W-1:0]] = link_t'(slot);
                        list_len = list_len + 1'b1;
                        res.push_back('{ST_OK, 32'd0, 1'b1});
                    end
                end
            end
            OP_PRINT:
            begin
                if (list_len == 0)
                begin
                    res.push_back('{ST_EMPTY, 32'd0, 1'b1});
                end
                else
                begin
                    p = link_t'(list_head);
                    for (int i = 0; i < list_len; i++)
                    begin
                        res.push_back('{ST_OK, word_mem[p[IDX_W-1:0]], (i + 1 == list_len)});
                        p = link_mem[p[IDX_W-1:0]];
                    end
                end
            end
            OP_CLEAR:
            begin
                rebuild_chains();
                res.push_back('{ST_OK, 32'd0, 1'b1});
            end
            default:
            begin
                // unused code: no transfer, no state change
            end
        endcase
    endfunction

    function automatic void add_row(op_t op, logic [31:0] value, idx_t slot,
                                    bit pinned, status_t status);
        script.push_back('{op, value, slot, pinned, status});
    endfunction

    // Offers one command and holds it until the input transfer completes. On return the
    // bench sits in the time step of the accepting edge with tvalid still high.
    task automatic send_command(op_t op, logic [31:0] value, idx_t slot);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0000, slot, value};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Sender gap: tvalid drops in this step and rises again at a later one.
    task automatic sender_gap();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
    endtask

    // Holds the sender back until every predicted transfer has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Receiver: random stall bursts, none once the run turns calm.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Output checker. Values read right at the edge are those the block drove into it.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected output transfer: status %0d item %h last %0d",
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata !== want.item)
                begin
                    $error("item: expected %h, got %h", want.item, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Stimulus: directed script, a drained pause, then random traffic.
    initial
    begin
        result_t     predicted[$];
        idx_t        free_slots[$];
        link_t       p;
        op_t         op;
        logic [31:0] value;
        idx_t        slot;
        int          pick;

        rebuild_chains();
        for (int i = 0; i < NODES; i++)
            word_mem[i] = '0;

        // Script: empty print, ignored code, taking the free tail and the free head,
        // a slot already in use, clear, then a full fill in scattered order so the
        // unlink hits the middle of the chain, a full append and a sixteen-word print.
        add_row(OP_PRINT,  32'h0000_0000, 4'd0,  1'b1, ST_EMPTY);
        add_row(OP_UNUSED, 32'hDEAD_BEEF, 4'd9,  1'b0, ST_OK);
        add_row(OP_APPEND, 32'h7FFF_FFFF, 4'd15, 1'b1, ST_OK);
        add_row(OP_APPEND, 32'h0000_0000, 4'd15, 1'b1, ST_NOT_FREE);
        add_row(OP_APPEND, 32'h8000_0000, 4'd0,  1'b1, ST_OK);
        add_row(OP_PRINT,  32'hFFFF_FFFF, 4'd15, 1'b0, ST_OK);
        add_row(OP_CLEAR,  32'h0000_0000, 4'd0,  1'b1, ST_OK);
        add_row(OP_PRINT,  32'h0000_0000, 4'd0,  1'b1, ST_EMPTY);
        // 7 is odd, so k*7+5 mod 16 visits every slot once
        for (int k = 0; k < NODES; k++)
            add_row(OP_APPEND, (32'hFFFF_FFFF >> k) ^ (32'h0000_0001 << (31 - k)),
                    idx_t'(k * 7 + 5), 1'b0, ST_OK);
        add_row(OP_APPEND, 32'h1234_5678, 4'd3,  1'b1, ST_FULL);
        add_row(OP_PRINT,  32'h0000_0000, 4'd0,  1'b0, ST_OK);

        // reset once; the block then sweeps its link RAM before taking input
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if ($urandom_range(0, 3) == 0)
                sender_gap();
            send_command(script[i].op, script[i].value, script[i].slot);
            list_step(script[i].op, script[i].value, script[i].slot, predicted);
            if (script[i].pinned)
                pending_results.push_back('{script[i].status, 32'd0, 1'b1});
            else
                foreach (predicted[j])
                    pending_results.push_back(predicted[j]);
        end

        wait_drained();

        // Random part: mostly appends to slots taken from the free chain so the list
        // fills and overflows; prints, clears, stray slots and the unused code mixed in.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
            pick = $urandom_range(0, 99);
            if (pick < 4)
                op = OP_CLEAR;
            else if (pick < 7)
                op = OP_UNUSED;
            else if (pick < 20)
                op = OP_PRINT;
            else
                op = OP_APPEND;

            case ($urandom_range(0, 11))
                0:       value = 32'h7FFF_FFFF;
                1:       value = 32'h8000_0000;
                2:       value = 32'h0000_0000;
                3:       value = 32'hFFFF_FFFF;
                default: value = $urandom;
            endcase

            free_slots = {};
            p = free_head;
            while (p != NIL)
            begin
                free_slots.push_back(p[IDX_W-1:0]);
                p = link_mem[p[IDX_W-1:0]];
            end
            if (free_slots.size() != 0 && $urandom_range(0, 3) != 0)
                slot = free_slots[$urandom_range(0, free_slots.size() - 1)];
            else
                slot = idx_t'($urandom_range(0, NODES - 1));

            if (!calm && $urandom_range(0, 3) == 0)
                sender_gap();
            send_command(op, value, slot);
            list_step(op, value, slot, predicted);
            foreach (predicted[j])
                pending_results.push_back(predicted[j]);
        end

        wait_drained();
        // an extra transfer arriving here is flagged by the checker
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog, several times the slowest legal run with stalls and sixteen-word prints.
    initial
    begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
